>>> hw/rtl/bfbf_pkg.sv
package bfbf_pkg;

  localparam int COORD_W        = 32;
  localparam int NUM_SIDES      = 6;
  localparam int FLAT_SIDES     = 4;
  localparam int SIDE_W         = 3;
  localparam int NUM_PHASES_DEF = 16;
  localparam int PHASE_W        = 8;
  localparam int APB_AW         = 5;
  localparam int APB_DW         = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   dist_t;
  typedef coord_t [NUM_SIDES-1:0]    box_t;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_REFINE   = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MAX_X = 3'd1,
    REG_BOX_MIN_Y = 3'd2,
    REG_BOX_MAX_Y = 3'd3,
    REG_BOX_MIN_Z = 3'd4,
    REG_BOX_MAX_Z = 3'd5,
    REG_PER_PHASE = 3'd6,
    REG_FLAT_MODE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              enclosed;
    logic [SIDE_W-1:0] side;
  } pick_t;

endpackage

>>> hw/rtl/bfbf_box_mem.sv
module bfbf_box_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output bfbf_pkg::box_t rd_data,
  output logic           rd_valid,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  bfbf_pkg::box_t wr_data
);
  import bfbf_pkg::*;

  box_t             mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  box_t             rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

  a_no_clr_and_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr && wr_en))
    else $error("box memory cleared and written in the same cycle");

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> valid_r == '0)
    else $error("valid bits survive a clear");

  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !clr) |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");

endmodule

>>> hw/rtl/bfbf_side_eval.sv
module bfbf_side_eval (
  input  logic            clk,
  input  logic            en,
  input  logic            flat,
  input  bfbf_pkg::box_t  box,
  input  bfbf_pkg::box_t  cvec,
  output bfbf_pkg::box_t  box_q,
  output bfbf_pkg::pick_t pick
);
  import bfbf_pkg::*;

  dist_t [NUM_SIDES-1:0] dist_r;
  box_t                  box_r;

  always_ff @(posedge clk) begin
    if (en) begin
      box_r <= box;
      for (int s = 0; s < NUM_SIDES; s++) begin
        if (s % 2 == 1) begin
          dist_r[s] <= dist_t'(box[s]) - dist_t'(cvec[s]);
        end else begin
          dist_r[s] <= dist_t'(cvec[s]) - dist_t'(box[s]);
        end
      end
    end
  end

  always_comb begin
    logic [COORD_W:0]  best;
    logic              all_in;
    logic [SIDE_W-1:0] side;
    best   = dist_r[0];
    all_in = 1'b1;
    side   = '0;
    for (int s = 0; s < NUM_SIDES; s++) begin
      if (!flat || s < FLAT_SIDES) begin
        if (dist_r[s][COORD_W] || dist_r[s] == '0) begin
          all_in = 1'b0;
        end else if (dist_r[s] < best) begin
          best = dist_r[s];
          side = SIDE_W'(s);
        end
      end
    end
    pick.enclosed = all_in;
    pick.side     = side;
  end

  assign box_q = box_r;

endmodule

>>> hw/rtl/biased_feature_box_finder_unit.sv
// Steps: the box memory read, the side distance stage (ST_EVAL) and the
//   nearest-side pick with write-back (ST_PICK) run in turn, and out_valid
//   rises as ST_PICK advances; a new word is taken only back in ST_IDLE.
// Reset: synchronous, active low; the state returns to ST_IDLE, out_valid,
//   configuration and base registers clear to zero, and every phase box reads
//   as the all-zero box through per-entry valid bits, no sweep.
module biased_feature_box_finder_unit #(
  parameter int NUM_PHASES = bfbf_pkg::NUM_PHASES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic signed [31:0]           in_pos_x,
  input  logic signed [31:0]           in_pos_y,
  input  logic signed [31:0]           in_pos_z,
  input  logic                         in_on_surface,
  input  logic [7:0]                   in_phase_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_biased,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfbf_pkg::APB_AW-1:0]  paddr,
  input  logic [bfbf_pkg::APB_DW-1:0]  pwdata,
  output logic [bfbf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import bfbf_pkg::*;

  localparam int AW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_PICK = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  box_t          cfg_box_r;
  logic          per_phase_r;
  logic          flat_mode_r;
  box_t          base_r;
  box_t          cvec_r;
  logic          op_refine_r;
  logic          op_class_r;
  logic [AW-1:0] addr_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_biased_r;

  logic          in_acc;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  cmd_t          cmd;
  logic          phase_ok;
  logic [7:0]    phase_m1;
  logic [AW-1:0] addr;
  box_t          rd_data;
  logic          rd_valid;
  box_t          box_in;
  box_t          box_q;
  box_t          box_w;
  pick_t         pick;
  logic          advance;
  logic          mem_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_box_r   <= '0;
      per_phase_r <= 1'b0;
      flat_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOX_MIN_X: cfg_box_r[0] <= coord_t'(pwdata);
        REG_BOX_MAX_X: cfg_box_r[1] <= coord_t'(pwdata);
        REG_BOX_MIN_Y: cfg_box_r[2] <= coord_t'(pwdata);
        REG_BOX_MAX_Y: cfg_box_r[3] <= coord_t'(pwdata);
        REG_BOX_MIN_Z: cfg_box_r[4] <= coord_t'(pwdata);
        REG_BOX_MAX_Z: cfg_box_r[5] <= coord_t'(pwdata);
        REG_PER_PHASE: per_phase_r  <= pwdata[0];
        REG_FLAT_MODE: flat_mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOX_MIN_X: prdata = APB_DW'(cfg_box_r[0]);
      REG_BOX_MAX_X: prdata = APB_DW'(cfg_box_r[1]);
      REG_BOX_MIN_Y: prdata = APB_DW'(cfg_box_r[2]);
      REG_BOX_MAX_Y: prdata = APB_DW'(cfg_box_r[3]);
      REG_BOX_MIN_Z: prdata = APB_DW'(cfg_box_r[4]);
      REG_BOX_MAX_Z: prdata = APB_DW'(cfg_box_r[5]);
      REG_PER_PHASE: prdata = {{(APB_DW-1){1'b0}}, per_phase_r};
      REG_FLAT_MODE: prdata = {{(APB_DW-1){1'b0}}, flat_mode_r};
      default:       prdata = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_cmd);
  assign phase_m1 = in_phase_id - 8'd1;

  always_comb begin
    if (flat_mode_r) begin
      phase_ok = 1'b1;
      addr     = '0;
    end else begin
      phase_ok = (in_phase_id != 8'd0) &&
                 ({1'b0, in_phase_id} <= (PHASE_W+1)'(NUM_PHASES));
      addr     = (per_phase_r && phase_ok) ? phase_m1[AW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cvec_r      <= {in_pos_z, in_pos_z, in_pos_y, in_pos_y, in_pos_x, in_pos_x};
      op_refine_r <= (cmd == CMD_REFINE) && in_on_surface && phase_ok;
      op_class_r  <= (cmd == CMD_CLASSIFY) && phase_ok;
      addr_r      <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (in_acc && cmd == CMD_START) begin
      base_r <= cfg_box_r;
    end
  end

  bfbf_box_mem #(
    .DEPTH (NUM_PHASES),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (in_acc && cmd == CMD_START),
    .rd_en    (in_acc),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr_en    (mem_wr),
    .wr_addr  (addr_r),
    .wr_data  (box_w)
  );

  assign box_in = rd_valid ? rd_data : base_r;

  bfbf_side_eval u_eval (
    .clk   (clk),
    .en    (state_r == ST_EVAL),
    .flat  (flat_mode_r),
    .box   (box_in),
    .cvec  (cvec_r),
    .box_q (box_q),
    .pick  (pick)
  );

  always_comb begin
    box_w            = box_q;
    box_w[pick.side] = cvec_r[pick.side];
  end

  assign advance = (state_r == ST_PICK) && (!out_valid_r || !out_stall);
  assign mem_wr  = advance && op_refine_r && pick.enclosed;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_PICK;
      ST_PICK: begin
        if (advance) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_biased_r <= op_class_r && !pick.enclosed;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_biased = out_biased_r;

  a_acc_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EVAL)
    else $error("accepted word did not enter the distance stage");

  a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PICK))
    else $error("result word raised outside the pick step");

  a_wr_only_refine: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> (state_r == ST_PICK) && op_refine_r && !op_class_r)
    else $error("box write-back without a refine");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_biased_r))
    else $error("stalled result word changed");

endmodule

>>> tb/biased_feature_box_finder_checker.sv
`timescale 1ns / 100ps
module biased_feature_box_finder_checker
  import bfbf_pkg::*;
#(
  parameter int NUM_PHASES = NUM_PHASES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic                in_on_surface,
  input  logic [7:0]          in_phase_id,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_biased,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  output int unsigned         error_count,
  output int unsigned         pending_count,
  output int unsigned         words_checked,
  output int unsigned         biased_seen,
  output int unsigned         sides_moved
);

  coord_t cfg_bound [NUM_SIDES];
  logic   cfg_per_phase;
  logic   cfg_flat;
  coord_t boxes [NUM_PHASES][NUM_SIDES];
  logic   biased_expected [$];

  function automatic void restore_boxes();
    for (int p = 0; p < NUM_PHASES; p++)
      for (int s = 0; s < NUM_SIDES; s++)
        boxes[p][s] = cfg_bound[s];
  endfunction

  function automatic logic apply_feature(cmd_t cmd, coord_t px, coord_t py, coord_t pz,
                                         logic surf, logic [PHASE_W-1:0] ph);
    longint pos [NUM_SIDES];
    longint span;
    longint nearest;
    int     sides;
    int     entry;
    int     pick;
    logic   all_in;
    logic   found;
    logic   hit;
    pos[0] = px;
    pos[1] = px;
    pos[2] = py;
    pos[3] = py;
    pos[4] = pz;
    pos[5] = pz;
    sides = cfg_flat ? FLAT_SIDES : NUM_SIDES;
    entry = 0;
    nearest = 0;
    pick = 0;
    all_in = 1'b1;
    found = 1'b0;
    hit = 1'b0;
    if (cmd == CMD_START) begin
      restore_boxes();
      return 1'b0;
    end
    if (cmd == CMD_NOP) return 1'b0;
    if (!cfg_flat) begin
      if (ph == 0 || ph > NUM_PHASES) return 1'b0;
      if (cfg_per_phase) entry = int'(ph) - 1;
    end
    if (cmd == CMD_REFINE && !surf) return 1'b0;
    for (int s = 0; s < sides; s++) begin
      if (s % 2 == 1) span = longint'(boxes[entry][s]) - pos[s];
      else span = pos[s] - longint'(boxes[entry][s]);
      if (span <= 0) begin
        all_in = 1'b0;
        hit = 1'b1;
      end else if (!found || span < nearest) begin
        nearest = span;
        pick = s;
        found = 1'b1;
      end
    end
    if (cmd == CMD_REFINE) begin
      if (all_in && found) begin
        boxes[entry][pick] = coord_t'(pos[pick]);
        sides_moved++;
      end
      return 1'b0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : monitor
    logic     want;
    reg_idx_t idx;
    if (!rst_n) begin
      foreach (cfg_bound[s]) cfg_bound[s] = '0;
      cfg_per_phase = 1'b0;
      cfg_flat = 1'b0;
      restore_boxes();
      biased_expected.delete();
      error_count = 0;
      words_checked = 0;
      biased_seen = 0;
      sides_moved = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[APB_AW-1:2]);
        case (idx)
          REG_PER_PHASE: cfg_per_phase = pwdata[0];
          REG_FLAT_MODE: cfg_flat = pwdata[0];
          default: cfg_bound[idx] = coord_t'(pwdata);
        endcase
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (out_biased) biased_seen++;
        if (biased_expected.size() == 0) begin
          report_mismatch($sformatf("result biased=%0b with nothing expected", out_biased));
        end else begin
          want = biased_expected.pop_front();
          if (out_biased !== want)
            report_mismatch($sformatf("result %0d: biased=%0b, expected %0b",
                                      words_checked, out_biased, want));
        end
      end
      if (in_valid && !in_stall)
        biased_expected.insert(biased_expected.size(),
                               apply_feature(cmd_t'(in_cmd), in_pos_x, in_pos_y, in_pos_z,
                                             in_on_surface, in_phase_id));
    end
    pending_count = biased_expected.size();
  end

endmodule

>>> tb/tb_biased_feature_box_finder_unit.sv
`timescale 1ns / 100ps
module tb_biased_feature_box_finder_unit;
  import bfbf_pkg::*;

  localparam int     IDLE_LIMIT   = 2000;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     RANDOM_WORDS = 100;
  localparam int     RANDOM_SETS  = 6;
  localparam coord_t COORD_MIN    = 32'sh8000_0000;
  localparam coord_t COORD_MAX    = 32'sh7fff_ffff;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic               in_on_surface;
  logic [7:0]         in_phase_id;
  logic               out_valid;
  logic               out_stall;
  logic               out_biased;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned words_checked;
  int unsigned biased_seen;
  int unsigned sides_moved;

  coord_t      bound_lo [3];
  coord_t      bound_hi [3];
  int          gap_pct;
  int          stall_pct;
  logic        quiet;
  int unsigned settings_used;

  biased_feature_box_finder_unit dut (.*);

  biased_feature_box_finder_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t fx(int whole);
    return coord_t'(whole * 65536);
  endfunction

  function automatic coord_t pick_coord(int axis);
    longint      lo;
    longint      hi;
    longint      tmp;
    logic [63:0] r;
    int unsigned sel;
    lo = bound_lo[axis];
    hi = bound_hi[axis];
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    r = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 60) return coord_t'(lo + longint'(r % 64'(hi - lo + 1)));
    if (sel < 80)
      return coord_t'(($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 2)) - 1);
    if (sel < 95) return coord_t'(r[31:0]);
    return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
  endfunction

  task automatic send_word(cmd_t cmd, coord_t x, coord_t y, coord_t z, logic surf,
                           logic [7:0] ph);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_on_surface <= surf;
    in_phase_id <= ph;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(logic per, logic flat);
    reg_write(REG_BOX_MIN_X, bound_lo[0]);
    reg_write(REG_BOX_MAX_X, bound_hi[0]);
    reg_write(REG_BOX_MIN_Y, bound_lo[1]);
    reg_write(REG_BOX_MAX_Y, bound_hi[1]);
    reg_write(REG_BOX_MIN_Z, bound_lo[2]);
    reg_write(REG_BOX_MAX_Z, bound_hi[2]);
    reg_write(REG_PER_PHASE, APB_DW'(per));
    reg_write(REG_FLAT_MODE, APB_DW'(flat));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** biased_feature_box_finder_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int          sel;
    int          w;
    cmd_t        cmd;
    logic [7:0]  ph;
    logic        per;
    logic        flat;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NOP;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_on_surface = 1'b0;
    in_phase_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    gap_pct = 0;
    stall_pct = 10;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_CLASSIFY, '0, '0, '0, 1'b1, 8'd1);
    send_word(CMD_REFINE, fx(1), fx(1), fx(1), 1'b1, 8'd1);
    drain();
    for (int a = 0; a < 3; a++) begin
      bound_lo[a] = fx(-100);
      bound_hi[a] = fx(100);
    end
    configure(1'b1, 1'b0);
    send_word(CMD_CLASSIFY, '0, '0, '0, 1'b1, 8'd1);
    send_word(CMD_START, '0, '0, '0, 1'b0, 8'd0);
    send_word(CMD_CLASSIFY, '0, '0, '0, 1'b1, 8'd1);
    send_word(CMD_CLASSIFY, fx(-100), '0, '0, 1'b1, 8'd1);
    send_word(CMD_CLASSIFY, '0, fx(100), '0, 1'b0, 8'd2);
    send_word(CMD_CLASSIFY, '0, '0, fx(-101), 1'b1, 8'd3);
    send_word(CMD_REFINE, fx(50), '0, '0, 1'b1, 8'd1);
    send_word(CMD_CLASSIFY, fx(60), '0, '0, 1'b1, 8'd1);
    send_word(CMD_CLASSIFY, fx(60), '0, '0, 1'b1, 8'd2);
    send_word(CMD_REFINE, fx(-90), '0, '0, 1'b0, 8'd1);
    send_word(CMD_CLASSIFY, fx(-95), '0, '0, 1'b1, 8'd1);
    send_word(CMD_REFINE, '0, '0, '0, 1'b1, 8'd3);
    send_word(CMD_CLASSIFY, '0, '0, '0, 1'b1, 8'd3);
    send_word(CMD_REFINE, fx(100), '0, '0, 1'b1, 8'd4);
    send_word(CMD_CLASSIFY, fx(99), '0, '0, 1'b1, 8'd4);
    send_word(CMD_CLASSIFY, fx(200), '0, '0, 1'b1, 8'd0);
    send_word(CMD_CLASSIFY, fx(200), '0, '0, 1'b1, 8'd17);
    send_word(CMD_REFINE, '0, '0, '0, 1'b1, 8'd255);
    send_word(CMD_NOP, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 8'd255);
    send_word(CMD_CLASSIFY, COORD_MAX, '0, '0, 1'b1, 8'd16);
    send_word(CMD_CLASSIFY, '0, COORD_MIN, COORD_MAX, 1'b0, 8'd16);
    send_word(CMD_REFINE, '0, '0, fx(99), 1'b1, 8'd5);
    drain();
    configure(1'b0, 1'b0);
    send_word(CMD_CLASSIFY, fx(60), '0, '0, 1'b1, 8'd1);
    send_word(CMD_CLASSIFY, '0, '0, '0, 1'b1, 8'd0);

    for (int p = 0; p < RANDOM_SETS; p++) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        w = $urandom_range(1, 300);
        bound_lo[a] = fx(-w) + coord_t'($urandom_range(0, 65535));
        bound_hi[a] = bound_lo[a] + fx($urandom_range(1, 600));
      end
      per = $urandom_range(0, 1);
      flat = $urandom_range(0, 1);
      case (p)
        0: begin
          bound_lo = '{COORD_MIN, COORD_MIN, COORD_MIN};
          bound_hi = '{COORD_MAX, COORD_MAX, COORD_MAX};
          per = 1'b0;
          flat = 1'b0;
        end
        1: begin
          per = 1'b1;
          flat = 1'b1;
        end
        2: begin
          bound_lo = '{fx(40), fx(40), fx(40)};
          bound_hi = '{fx(-40), fx(-40), fx(-40)};
          per = 1'b1;
          flat = 1'b0;
        end
        3: begin
          for (int a = 0; a < 3; a++) begin
            bound_lo[a] = coord_t'($urandom);
            bound_hi[a] = coord_t'($urandom);
          end
        end
        4: begin
          per = 1'b1;
          flat = 1'b0;
        end
        default: ;
      endcase
      configure(per, flat);
      quiet = (p == RANDOM_SETS - 1);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        if (n % 25 == 0) begin
          gap_pct = quiet ? 0 : 8 * $urandom_range(0, 3);
          stall_pct = quiet ? 0 : 5 * $urandom_range(0, 3);
        end
        sel = $urandom_range(0, 99);
        cmd = (sel < 4) ? CMD_START : (sel < 50) ? CMD_REFINE :
              (sel < 95) ? CMD_CLASSIFY : CMD_NOP;
        sel = $urandom_range(0, 99);
        if (sel < 45) ph = 8'($urandom_range(1, 3));
        else if (sel < 90) ph = 8'($urandom_range(1, NUM_PHASES_DEF));
        else ph = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < gap_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        send_word(cmd, pick_coord(0), pick_coord(1), pick_coord(2),
                  $urandom_range(0, 99) < 80, ph);
      end
    end

    drain();
    $display("run covered %0d result words, %0d of them biased, over %0d register settings",
             words_checked, biased_seen, settings_used);
    $display("refines moved %0d box sides in total", sides_moved);
    if (error_count == 0) begin
      $display("** biased_feature_box_finder_unit: PASSED **");
    end else begin
      $display("** biased_feature_box_finder_unit: FAILED **");
    end
    $finish;
  end

endmodule
